/* hw/rtl/erf_pkg.sv */
// ----------------------------------------------------------------------------
// erf_pkg: shared types, constants and helpers for the erf/r series block
// Request structs for the shared multiplier and the small-divisor divider,
// configuration register indexes and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package erf_pkg;

	// Default configuration of the series engine
	localparam int MAX_TERMS_DEF = 32;
	localparam int FRAC_BITS_DEF = 40;

	// Quotient bits resolved per divider cycle, and cycles per 64-bit divide
	localparam int DIV_STEP   = 8;
	localparam int DIV_CYCLES = 64 / DIV_STEP;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_ALPHA_SQ       = 2'd0,
		CFG_VALUE_SCALE    = 2'd1,
		CFG_DERIV_SCALE    = 2'd2,
		CFG_STOP_THRESHOLD = 2'd3
	} cfg_idx_t;

	// Multiply request: magnitudes, optional fraction shift, result sign
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic        frac;
		logic        neg;
	} mul_req_t;

	// Divide request: magnitude of the dividend and its sign
	typedef struct packed {
		logic        start;
		logic [63:0] mag;
		logic        neg;
	} div_req_t;

	// Magnitude of a signed word; the most negative value maps to 2^63
	function automatic logic [63:0] mag_of(input logic signed [63:0] v);
		logic [63:0] u;
		u = v;
		return v[63] ? (~u + 64'd1) : u;
	endfunction

	// Add with saturation to the signed 64-bit range
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	// Negate with saturation
	function automatic logic signed [63:0] neg_sat(input logic signed [63:0] v);
		return (v == S64_MIN) ? S64_MAX : -v;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/erf_mul.sv */
// ----------------------------------------------------------------------------
// erf_mul: shared iterative 64x64 multiplier
// Builds the 128-bit product of two magnitudes from four 32x32 partial
// products, one per cycle, then shifts out the fraction if requested and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module erf_mul
	import erf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mul_req_t           req,
	output logic signed [63:0]      res,
	output logic                    done
);

	logic [63:0]  a_q, b_q;
	logic         frac_q, neg_q;
	logic [1:0]   idx_q;
	logic         issue_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic         ppv_s1, last_s1;
	logic [127:0] acc_q;
	logic         fin_q;
	logic signed [63:0] res_q;
	logic         done_q;

	logic [31:0]  a_part, b_part;
	logic [127:0] pp_wide;
	logic [127:0] shifted;
	logic         hi_nz;

	// Select the operand halves for this partial product
	assign a_part = idx_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = idx_q[0] ? b_q[63:32] : b_q[31:0];

	// Align the registered partial product
	always_comb begin
		case (sh_s1)
			2'd0:    pp_wide = {64'd0, pp_s1};
			2'd1:    pp_wide = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_wide = {pp_s1, 64'd0};
			default: pp_wide = '0;
		endcase
	end

	// Drop the fraction bits and check for overflow of the signed range
	assign shifted = frac_q ? (acc_q >> FRAC_BITS) : acc_q;
	assign hi_nz   = |shifted[127:63];

	// Operand capture and partial product issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			idx_q   <= '0;
			ppv_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			ppv_s1  <= issue_q;
			last_s1 <= issue_q && (idx_q == 2'd3);
			if (req.start) begin
				issue_q <= 1'b1;
				idx_q   <= '0;
			end else if (issue_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a;
			b_q    <= req.b;
			frac_q <= req.frac;
			neg_q  <= req.neg;
		end
		pp_s1 <= a_part * b_part;
		sh_s1 <= {1'b0, idx_q[1]} + {1'b0, idx_q[0]};
	end

	// Accumulate partial products, then saturate into the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fin_q  <= ppv_s1 && last_s1;
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
		end else if (ppv_s1) begin
			acc_q <= acc_q + pp_wide;
		end
		if (fin_q) begin
			if (neg_q) begin
				res_q <= hi_nz ? S64_MIN : -$signed(shifted[63:0]);
			end else begin
				res_q <= hi_nz ? S64_MAX : $signed(shifted[63:0]);
			end
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* hw/rtl/erf_div.sv */
// ----------------------------------------------------------------------------
// erf_div: iterative divider for small integer divisors
// Divides a 64-bit magnitude by a narrow divisor, a group of quotient bits
// per cycle by restoring steps, and restores the sign of the dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module erf_div
	import erf_pkg::*;
#(
	parameter int KW = 7
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire div_req_t           req,
	input  wire logic [KW-1:0]      k,
	output logic signed [63:0]      res,
	output logic                    done
);

	localparam int CW = $clog2(DIV_CYCLES);

	logic [63:0]   dvd_q, quo_q;
	logic [KW:0]   rem_q;
	logic [KW-1:0] k_q;
	logic          neg_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic signed [63:0] res_q;
	logic          done_q;

	logic [63:0]   dvd_nxt, quo_nxt;
	logic [KW:0]   rem_nxt;

	// Resolve one group of quotient bits
	always_comb begin
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		quo_nxt = quo_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			rem_nxt = {rem_nxt[KW-1:0], dvd_nxt[63]};
			dvd_nxt = {dvd_nxt[62:0], 1'b0};
			if (rem_nxt >= {1'b0, k_q}) begin
				rem_nxt = rem_nxt - {1'b0, k_q};
				quo_nxt = {quo_nxt[62:0], 1'b1};
			end else begin
				quo_nxt = {quo_nxt[62:0], 1'b0};
			end
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold dividend, remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.mag;
			quo_q <= '0;
			rem_q <= '0;
			k_q   <= k;
			neg_q <= req.neg;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
			if (cnt_q == CW'(DIV_CYCLES - 1)) begin
				res_q <= neg_q ? -$signed(quo_nxt) : $signed(quo_nxt);
			end
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* hw/rtl/erf_over_r_taylor_series.sv */
// ----------------------------------------------------------------------------
// erf_over_r_taylor_series: Ewald erf(r)/r correction by Taylor series
// Scales a squared distance by alpha squared, sums the alternating series
// terms and applies the value and derivative coefficients, in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func and dist_sq; the output
//   channel (out_valid/out_stall) returns value_out, deriv_out and
//   terms_capped, one result beat per input beat, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   One item is in flight at a time: in_stall is high from the accepted
//   beat until its result has been loaded into the output register.
//   Every step runs on one shared 32x32 multiplier (four partial products
//   per 64x64 product) and one small-divisor divider (8 quotient bits per
//   cycle). One series term takes two divides and two products; the last
//   term skips its update, and the scaling product and the three closing
//   products are added to the terms. N terms run, N from 1 to MAX_TERMS.
//   The output register holds a finished result while out_stall is high;
//   the next item is accepted meanwhile and waits at its end for the slot.
//   Reset clears the sequencer and the output valid and loads the register
//   defaults: alpha_sq 1.0, both scales 0, stop threshold 256.
// ----------------------------------------------------------------------------
`default_nettype none

module erf_over_r_taylor_series
	import erf_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire cfg_idx_t           cfg_index,
	input  wire logic [56:0]        cfg_data,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               func,
	input  wire logic [47:0]        dist_sq,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [63:0]      value_out,
	output logic signed [63:0]      deriv_out,
	output logic                    terms_capped
);

	localparam int NW = $clog2(MAX_TERMS + 1);
	localparam int KW = $clog2(2 * MAX_TERMS + 2);
	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_XMUL   = 11'b000_0000_0010,
		S_TSTART = 11'b000_0000_0100,
		S_TDIV   = 11'b000_0000_1000,
		S_NMUL   = 11'b000_0001_0000,
		S_QMUL   = 11'b000_0010_0000,
		S_QDIV   = 11'b000_0100_0000,
		S_SUMUL  = 11'b000_1000_0000,
		S_AMUL   = 11'b001_0000_0000,
		S_BMUL   = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_nxt;

	// Configuration registers
	logic [47:0]        alpha_sq_q;
	logic signed [56:0] value_scale_q;
	logic signed [56:0] deriv_scale_q;
	logic [39:0]        stop_threshold_q;

	// Series state
	logic               mode_q;
	logic signed [63:0] x_q, q_q, t_q, su_q, sd_q, val_q;
	logic [NW-1:0]      n_q;
	logic               capped_q;

	// Output register
	logic               out_valid_q;
	logic signed [63:0] value_out_q, deriv_out_q;
	logic               terms_capped_q;

	// Shared units
	mul_req_t           mreq;
	div_req_t           dreq;
	logic [KW-1:0]      dk;
	logic signed [63:0] mres, dres;
	logic               mdone, ddone;

	logic               in_acc, out_load;
	logic signed [63:0] su_new, sd_new, xsu_neg, val_pre;
	logic signed [63:0] vscale_ext, dscale_ext;
	logic               below, at_cap;

	erf_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.res   (mres),
		.done  (mdone)
	);

	erf_div #(
		.KW(KW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.k     (dk),
		.res   (dres),
		.done  (ddone)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Term sums and stop checks, used as the term product returns
	assign sd_new     = sat_add(sd_q, mres);
	assign su_new     = sat_add(su_q, t_q);
	assign below      = mag_of(q_q) < {24'd0, stop_threshold_q};
	assign at_cap     = (n_q >= NW'(MAX_TERMS));
	assign xsu_neg    = neg_sat(mres);
	assign val_pre    = mode_q ? xsu_neg : sat_add(ONE_Q, xsu_neg);
	assign vscale_ext = 64'(value_scale_q);
	assign dscale_ext = 64'(deriv_scale_q);

	// Sequencer: issue work to the shared units and advance
	always_comb begin
		state_nxt = state_q;
		mreq      = '0;
		dreq      = '0;
		dk        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					mreq.start = 1'b1;
					mreq.a     = {16'd0, alpha_sq_q};
					mreq.b     = {16'd0, dist_sq};
					mreq.frac  = 1'b1;
					state_nxt  = S_XMUL;
				end
			end
			S_XMUL: begin
				if (mdone) begin
					state_nxt = S_TSTART;
				end
			end
			S_TSTART: begin
				dreq.start = 1'b1;
				dreq.mag   = mag_of(q_q);
				dreq.neg   = q_q[63];
				dk         = KW'({n_q, 1'b1});
				state_nxt  = S_TDIV;
			end
			S_TDIV: begin
				if (ddone) begin
					mreq.start = 1'b1;
					mreq.a     = mag_of(dres);
					mreq.b     = 64'(n_q);
					mreq.neg   = dres[63];
					state_nxt  = S_NMUL;
				end
			end
			S_NMUL: begin
				if (mdone) begin
					mreq.start = 1'b1;
					mreq.frac  = 1'b1;
					if (below || at_cap) begin
						mreq.a    = mag_of(x_q);
						mreq.b    = mag_of(su_new);
						mreq.neg  = x_q[63] ^ su_new[63];
						state_nxt = S_SUMUL;
					end else begin
						mreq.a    = mag_of(q_q);
						mreq.b    = mag_of(x_q);
						mreq.neg  = q_q[63] ^ x_q[63];
						state_nxt = S_QMUL;
					end
				end
			end
			S_QMUL: begin
				if (mdone) begin
					dreq.start = 1'b1;
					dreq.mag   = mag_of(mres);
					dreq.neg   = mres[63];
					dk         = KW'(n_q + NW'(1));
					state_nxt  = S_QDIV;
				end
			end
			S_QDIV: begin
				if (ddone) begin
					state_nxt = S_TSTART;
				end
			end
			S_SUMUL: begin
				if (mdone) begin
					mreq.start = 1'b1;
					mreq.a     = mag_of(vscale_ext);
					mreq.b     = mag_of(val_pre);
					mreq.frac  = 1'b1;
					mreq.neg   = vscale_ext[63] ^ val_pre[63];
					state_nxt  = S_AMUL;
				end
			end
			S_AMUL: begin
				if (mdone) begin
					mreq.start = 1'b1;
					mreq.a     = mag_of(dscale_ext);
					mreq.b     = mag_of(sd_q);
					mreq.frac  = 1'b1;
					mreq.neg   = dscale_ext[63] ^ sd_q[63];
					state_nxt  = S_BMUL;
				end
			end
			S_BMUL: begin
				if (mdone) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Control state, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			out_valid_q      <= 1'b0;
			alpha_sq_q       <= 48'h0100_0000_0000;
			value_scale_q    <= '0;
			deriv_scale_q    <= '0;
			stop_threshold_q <= 40'd256;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ALPHA_SQ:       alpha_sq_q       <= cfg_data[47:0];
					CFG_VALUE_SCALE:    value_scale_q    <= cfg_data;
					CFG_DERIV_SCALE:    deriv_scale_q    <= cfg_data;
					CFG_STOP_THRESHOLD: stop_threshold_q <= cfg_data[39:0];
					default: ;
				endcase
			end
		end
	end

	// Series datapath: capture unit results as the sequencer advances
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= func;
		end
		case (state_q)
			S_XMUL: begin
				if (mdone) begin
					x_q      <= mres;
					q_q      <= ONE_Q;
					n_q      <= NW'(1);
					su_q     <= '0;
					sd_q     <= '0;
					capped_q <= 1'b0;
				end
			end
			S_TDIV: begin
				if (ddone) begin
					t_q <= dres;
				end
			end
			S_NMUL: begin
				if (mdone) begin
					sd_q     <= sd_new;
					su_q     <= su_new;
					capped_q <= !below && at_cap;
				end
			end
			S_QDIV: begin
				if (ddone) begin
					q_q <= -dres;
					n_q <= n_q + NW'(1);
				end
			end
			S_AMUL: begin
				if (mdone) begin
					val_q <= mres;
				end
			end
			S_OUT: begin
				if (out_load) begin
					value_out_q    <= val_q;
					deriv_out_q    <= sd_q;
					terms_capped_q <= capped_q;
				end
			end
			default: ;
		endcase
		// hold the derivative product until the result beat is loaded
		if (state_q == S_BMUL && mdone) begin
			sd_q <= mres;
		end
	end

	assign out_valid    = out_valid_q;
	assign value_out    = value_out_q;
	assign deriv_out    = deriv_out_q;
	assign terms_capped = terms_capped_q;

endmodule

`default_nettype wire
